>>> hw/rtl/bot_pkg.sv
// shared types, codes and constants of the bulk-only transport host engine
// no dependencies; imported by every module of the block
`default_nettype none

package bot_pkg;

    localparam int unsigned CHUNK_BYTES_DEF = 4096;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned CFG_WIDTH   = 33;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECTOR_LOG2 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_READY  = 2'd2;

    localparam logic [4:0] SECTOR_LOG2_RESET = 5'd9;
    localparam logic [4:0] SECTOR_LOG2_MIN   = 5'd9;
    localparam logic [4:0] SECTOR_LOG2_MAX   = 5'd16;

    localparam logic [2:0] MODE_READ10  = 3'd0;
    localparam logic [2:0] MODE_WRITE10 = 3'd1;
    localparam logic [2:0] MODE_TUR     = 3'd2;
    localparam logic [2:0] MODE_SENSE   = 3'd3;
    localparam logic [2:0] MODE_DONE    = 3'd4;

    localparam logic [31:0] SIG_CMD      = 32'h4342_5355;
    localparam logic [31:0] SIG_STAT     = 32'h5342_5355;
    localparam logic [7:0]  OP_READ10    = 8'h28;
    localparam logic [7:0]  OP_WRITE10   = 8'h2A;
    localparam logic [7:0]  OP_SENSE     = 8'h03;
    localparam logic [7:0]  OP_TUR       = 8'h00;
    localparam logic [7:0]  FLAG_DATA_IN = 8'h80;
    localparam logic [7:0]  SENSE_LEN    = 8'd18;
    localparam logic [7:0]  CDB_LEN_10   = 8'd10;
    localparam logic [7:0]  CDB_LEN_6    = 8'd6;

    localparam int unsigned CBW_BYTES = 31;
    localparam int unsigned CBW_IDX_W = $clog2(CBW_BYTES);
    localparam logic [CBW_IDX_W-1:0] CBW_LAST = CBW_IDX_W'(CBW_BYTES - 1);

    typedef enum logic [2:0] {
        KIND_CMD_BYTE = 3'd0,
        KIND_CHUNK    = 3'd1,
        KIND_STATUS   = 3'd2,
        KIND_RESET    = 3'd3,
        KIND_RESULT   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        RC_PASS        = 2'd0,
        RC_REJECTED    = 2'd1,
        RC_TRANSPORT   = 2'd2,
        RC_STATUS_FAIL = 2'd3
    } rc_t;

    typedef enum logic [2:0] {
        JOB_CMD    = 3'd0,
        JOB_RESULT = 3'd1,
        JOB_CHUNK  = 3'd2,
        JOB_STATUS = 3'd3,
        JOB_RESET  = 3'd4
    } job_op_t;

    typedef struct packed {
        job_op_t     op;
        rc_t         rc;
        logic [12:0] chunk;
        logic        dir_in;
        logic        cdb10;
        logic [7:0]  opcode;
        logic [31:0] tag;
        logic [31:0] len;
        logic [31:0] lba;
        logic [15:0] count;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } job_push_t;

    // command block wrapper byte in wire order
    function automatic logic [7:0] cbw_byte(input job_t j, input logic [CBW_IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            5'd0:  b = SIG_CMD[7:0];
            5'd1:  b = SIG_CMD[15:8];
            5'd2:  b = SIG_CMD[23:16];
            5'd3:  b = SIG_CMD[31:24];
            5'd4:  b = j.tag[7:0];
            5'd5:  b = j.tag[15:8];
            5'd6:  b = j.tag[23:16];
            5'd7:  b = j.tag[31:24];
            5'd8:  b = j.len[7:0];
            5'd9:  b = j.len[15:8];
            5'd10: b = j.len[23:16];
            5'd11: b = j.len[31:24];
            5'd12: b = j.dir_in ? FLAG_DATA_IN : 8'h00;
            5'd14: b = j.cdb10 ? CDB_LEN_10 : CDB_LEN_6;
            5'd15: b = j.opcode;
            5'd17: b = j.lba[31:24];
            5'd18: b = j.lba[23:16];
            5'd19: b = j.lba[15:8];
            5'd20: b = j.lba[7:0];
            5'd22: b = j.count[15:8];
            5'd23: b = j.count[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bot_if.sv
// handshake channels of the bulk-only transport host engine
// command/completion channel in, result channel out; no dependencies
`default_nettype none

interface bot_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] lba;
    logic [15:0] sector_count;
    logic        xfer_ok;
    logic [31:0] csw_signature;
    logic [31:0] csw_tag;
    logic [7:0]  csw_status;

    modport source (output valid, mode, lba, sector_count, xfer_ok, csw_signature,
                    csw_tag, csw_status, input ready);
    modport sink (input valid, mode, lba, sector_count, xfer_ok, csw_signature,
                  csw_tag, csw_status, output ready);
endinterface

interface bot_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [12:0] chunk_length;
    logic        direction_in;
    logic [1:0]  result_code;
    logic        last;

    modport source (output valid, kind, byte_value, chunk_length, direction_in,
                    result_code, last, input ready);
    modport sink (input valid, kind, byte_value, chunk_length, direction_in,
                  result_code, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bot_front.sv
// front end: configuration registers, command checks and transfer phase tracking
// depends on bot_pkg and bot_cmd_if; pushes jobs into bot_queue
`default_nettype none

module bot_front #(
    parameter int unsigned CHUNK_BYTES = bot_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    bot_cmd_if.sink                              cmd,
    input  wire logic                            cfg_we,
    input  wire logic [bot_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bot_pkg::CFG_WIDTH-1:0]   cfg_wdata,
    input  wire logic                            q_full,
    output bot_pkg::job_push_t                   q_push
);
    import bot_pkg::*;

    localparam int unsigned CW = $clog2(CHUNK_BYTES + 1);
    localparam logic [31:0] CHUNK32 = 32'(CHUNK_BYTES);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_CMD    = 2'd1,
        PH_DATA   = 2'd2,
        PH_STATUS = 2'd3
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [31:0]     tag_reg, tag_next;
    logic [31:0]     remain_reg, remain_next;
    logic            dir_reg, dir_next;
    logic [CW-1:0]   chunk_reg, chunk_next;
    logic [4:0]      sec_log2_reg;
    logic [32:0]     capacity_reg;
    logic            ready_unit_reg;

    logic            accept;
    logic            is_rw;
    logic            reject;
    logic [4:0]      shift;
    logic [31:0]     len_c;
    logic            dir_c;
    logic [7:0]      opcode_c;
    logic [31:0]     lba_c;
    logic [15:0]     count_c;
    logic [31:0]     remain_sub;
    logic [31:0]     remain_eff;
    logic [31:0]     chunk32;
    logic            csw_good;
    job_t            job;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && !q_full;

    assign is_rw  = (cmd.mode == MODE_READ10) || (cmd.mode == MODE_WRITE10);
    assign reject = !ready_unit_reg || (cmd.sector_count == 16'd0)
                    || (({1'b0, cmd.lba} + {17'd0, cmd.sector_count}) > capacity_reg);
    assign shift  = (sec_log2_reg < SECTOR_LOG2_MIN) ? SECTOR_LOG2_MIN
                  : ((sec_log2_reg > SECTOR_LOG2_MAX) ? SECTOR_LOG2_MAX : sec_log2_reg);

    always_comb
    begin
        len_c    = 32'd0;
        dir_c    = 1'b0;
        opcode_c = OP_TUR;
        lba_c    = 32'd0;
        count_c  = 16'd0;
        case (cmd.mode)
            MODE_READ10:
            begin
                len_c    = 32'(cmd.sector_count) << shift;
                dir_c    = 1'b1;
                opcode_c = OP_READ10;
                lba_c    = cmd.lba;
                count_c  = cmd.sector_count;
            end
            MODE_WRITE10:
            begin
                len_c    = 32'(cmd.sector_count) << shift;
                opcode_c = OP_WRITE10;
                lba_c    = cmd.lba;
                count_c  = cmd.sector_count;
            end
            MODE_SENSE:
            begin
                len_c    = 32'(SENSE_LEN);
                dir_c    = 1'b1;
                opcode_c = OP_SENSE;
                // allocation length lands in cdb byte 4
                lba_c    = {16'd0, SENSE_LEN, 8'd0};
            end
            default: ;
        endcase
    end

    assign remain_sub = (32'(chunk_reg) >= remain_reg) ? 32'd0 : remain_reg - 32'(chunk_reg);
    assign remain_eff = (phase_reg == PH_DATA) ? remain_sub : remain_reg;
    assign chunk32    = (remain_eff < CHUNK32) ? remain_eff : CHUNK32;
    assign csw_good   = (cmd.csw_signature == SIG_STAT) && (cmd.csw_tag == tag_reg)
                        && (cmd.csw_status == 8'd0);

    always_comb
    begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        remain_next = remain_reg;
        dir_next    = dir_reg;
        chunk_next  = chunk_reg;
        job         = '0;
        q_push.push = 1'b0;
        if (accept)
        begin
            case (cmd.mode)
                MODE_READ10, MODE_WRITE10, MODE_TUR, MODE_SENSE:
                begin
                    q_push.push = 1'b1;
                    if ((phase_reg != PH_IDLE) || (is_rw && reject))
                    begin
                        job.op = JOB_RESULT;
                        job.rc = RC_REJECTED;
                    end
                    else
                    begin
                        tag_next    = tag_reg + 32'd1;
                        remain_next = len_c;
                        dir_next    = dir_c;
                        chunk_next  = '0;
                        phase_next  = PH_CMD;
                        job.op      = JOB_CMD;
                        job.tag     = tag_reg + 32'd1;
                        job.len     = len_c;
                        job.dir_in  = dir_c;
                        job.cdb10   = is_rw;
                        job.opcode  = opcode_c;
                        job.lba     = lba_c;
                        job.count   = count_c;
                    end
                end
                MODE_DONE:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        q_push.push = 1'b1;
                        if (!cmd.xfer_ok)
                        begin
                            job.op      = JOB_RESET;
                            phase_next  = PH_IDLE;
                            remain_next = 32'd0;
                        end
                        else if (phase_reg == PH_STATUS)
                        begin
                            job.op     = JOB_RESULT;
                            job.rc     = csw_good ? RC_PASS : RC_STATUS_FAIL;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            remain_next = remain_eff;
                            if (remain_eff != 32'd0)
                            begin
                                chunk_next = chunk32[CW-1:0];
                                phase_next = PH_DATA;
                                job.op     = JOB_CHUNK;
                                job.chunk  = chunk32[12:0];
                                job.dir_in = dir_reg;
                            end
                            else
                            begin
                                phase_next = PH_STATUS;
                                job.op     = JOB_STATUS;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        q_push.job = job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tag_reg    <= 32'd0;
            remain_reg <= 32'd0;
            dir_reg    <= 1'b0;
            chunk_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            remain_reg <= remain_next;
            dir_reg    <= dir_next;
            chunk_reg  <= chunk_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_log2_reg   <= SECTOR_LOG2_RESET;
            capacity_reg   <= 33'd0;
            ready_unit_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SECTOR_LOG2: sec_log2_reg   <= cfg_wdata[4:0];
                CFG_CAPACITY:    capacity_reg   <= cfg_wdata[32:0];
                CFG_UNIT_READY:  ready_unit_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bot_queue.sv
// short job queue between the front end and the result sequencer
// depends on bot_pkg for the job type
`default_nettype none

module bot_queue #(
    parameter int unsigned DEPTH = bot_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire bot_pkg::job_push_t wr,
    output logic              full,
    input  wire logic         pop,
    output logic              rd_valid,
    output bot_pkg::job_t     rd_data
);
    import bot_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_MAX = AW'(DEPTH - 1);

    job_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full     = (count_reg == NW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (!do_push && do_pop)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bot_back.sv
// result sequencer: expands queued jobs into result transfers; depends on bot_pkg, bot_res_if
// one result per cycle from an output register while res.ready is high
`default_nettype none

module bot_back (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_valid,
    input  wire bot_pkg::job_t q_job,
    output logic           q_pop,
    bot_res_if.source      res
);
    import bot_pkg::*;

    logic [CBW_IDX_W-1:0] idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    kind_t                kind_reg, kind_c;
    logic [7:0]           byte_reg, byte_c;
    logic [12:0]          chunk_reg, chunk_c;
    logic                 dir_reg, dir_c;
    rc_t                  rc_reg, rc_c;
    logic                 last_reg, last_c;
    logic                 load;

    assign load = !valid_reg || res.ready;

    always_comb
    begin
        kind_c  = KIND_RESULT;
        byte_c  = 8'h00;
        chunk_c = 13'd0;
        dir_c   = 1'b0;
        rc_c    = RC_PASS;
        last_c  = 1'b1;
        case (q_job.op)
            JOB_CMD:
            begin
                kind_c = KIND_CMD_BYTE;
                byte_c = cbw_byte(q_job, idx_reg);
                last_c = (idx_reg == CBW_LAST);
            end
            JOB_RESET:
            begin
                if (idx_reg == '0)
                begin
                    kind_c = KIND_RESET;
                    last_c = 1'b0;
                end
                else
                begin
                    rc_c = RC_TRANSPORT;
                end
            end
            JOB_CHUNK:
            begin
                kind_c  = KIND_CHUNK;
                chunk_c = q_job.chunk;
                dir_c   = q_job.dir_in;
            end
            JOB_STATUS: kind_c = KIND_STATUS;
            JOB_RESULT: rc_c = q_job.rc;
            default: ;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        if (load)
        begin
            valid_next = q_valid;
            if (q_valid)
            begin
                q_pop    = last_c;
                idx_next = last_c ? '0 : idx_reg + CBW_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && q_valid)
        begin
            kind_reg  <= kind_c;
            byte_reg  <= byte_c;
            chunk_reg <= chunk_c;
            dir_reg   <= dir_c;
            rc_reg    <= rc_c;
            last_reg  <= last_c;
        end
    end

    assign res.valid        = valid_reg;
    assign res.kind         = kind_reg;
    assign res.byte_value   = byte_reg;
    assign res.chunk_length = chunk_reg;
    assign res.direction_in = dir_reg;
    assign res.result_code  = rc_reg;
    assign res.last         = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bulk_only_transport_host_engine.sv
// an accepted item is written into the job queue, then its first result is registered
// in the output register; throughput: an item is taken every cycle while the job
// queue has room; results leave one per cycle through the output register while
// res.ready is high; a command yields 31 results and a completion one or two
// reset: rst_n clears phase, tag, byte count, queue and output valid at once
// top level: front end, job queue and result sequencer; depends on bot_pkg, bot_if
`default_nettype none

module bulk_only_transport_host_engine #(
    parameter int unsigned CHUNK_BYTES = bot_pkg::CHUNK_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH = bot_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    bot_cmd_if.sink                              cmd,
    bot_res_if.source                            res,
    input  wire logic                            cfg_we,
    input  wire logic [bot_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bot_pkg::CFG_WIDTH-1:0]   cfg_wdata
);
    import bot_pkg::*;

    job_push_t q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    job_t      q_job;

    bot_front #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push)
    );

    bot_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_push),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_job)
    );

    bot_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .res     (res)
    );

`ifndef ASSERT_OFF
    a_reset_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == KIND_RESET) |-> !res.last)
        else $error("reset request marked last");

    a_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == KIND_RESULT) |-> res.last)
        else $error("command result not last");

    a_reset_then_error: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready && (res.kind == KIND_RESET) |=>
        res.valid && (res.kind == KIND_RESULT) && (res.result_code == RC_TRANSPORT))
        else $error("reset request not followed by transport error");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !cmd.ready)
        else $error("input taken with full queue");
`endif

endmodule

`default_nettype wire
